// ===== rtl/ptt_pkg.sv =====
// Shared types and constants for the pan/tilt tracker with search sweep.
package ptt_pkg;

  localparam int POS_W  = 12;
  localparam int PIX_W  = 10;
  localparam int STEP_W = 8;
  localparam int WP_W   = 2;
  localparam int CFG_W  = 3;
  localparam int DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] REG_CENTER_X       = 3'd0;
  localparam logic [CFG_W-1:0] REG_CENTER_Y       = 3'd1;
  localparam logic [CFG_W-1:0] REG_PAN_MIN        = 3'd2;
  localparam logic [CFG_W-1:0] REG_PAN_MAX        = 3'd3;
  localparam logic [CFG_W-1:0] REG_TILT_MIN       = 3'd4;
  localparam logic [CFG_W-1:0] REG_TILT_MAX       = 3'd5;
  localparam logic [CFG_W-1:0] REG_SEARCH_TILT    = 3'd6;
  localparam logic [CFG_W-1:0] REG_SEARCH_PAN_MID = 3'd7;

  // Sweep waypoint codes
  localparam logic [WP_W-1:0] WP_MID_OUT = 2'd0;
  localparam logic [WP_W-1:0] WP_MAX     = 2'd1;
  localparam logic [WP_W-1:0] WP_MID_IN  = 2'd2;
  localparam logic [WP_W-1:0] WP_MIN     = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] ball_x;
    logic [PIX_W-1:0] ball_y;
    logic             ball_lost;
    logic [POS_W-1:0] pan_position;
    logic [POS_W-1:0] tilt_position;
  } tick_t;

  typedef struct packed {
    logic [POS_W-1:0] pan_command;
    logic [POS_W-1:0] tilt_command;
    logic             searching;
  } cmd_t;

  // Work handed from the front to the back. Tracking jobs carry the
  // finished command as both start and goal, so the interpolator adds zero.
  typedef struct packed {
    logic              searching;
    logic [STEP_W-1:0] step;
    logic [POS_W-1:0]  start_pan;
    logic [POS_W-1:0]  start_tilt;
    logic [POS_W-1:0]  goal_pan;
    logic [POS_W-1:0]  goal_tilt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/pan_tilt_tracker_with_sweep.sv =====
// Top level of the pan/tilt ball tracker with minimum-jerk search sweep.
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+-----------------------
//  config  | cfg_write, cfg_index, cfg_data  | in        | register write
//  tick    | tick_valid, tick_stall, tick    | in        | ball pixel, lost, servo pos
//  cmd     | cmd_valid, cmd_stall, cmd       | out       | pan/tilt command, searching
//
// One tick is accepted per clock while the queue is not full; each yields one
// command via the queue and the back-end weight lookup, multiply, round-and-add stages.
// Sustained rate is one transaction per cycle while cmd_stall is low, set by the
// front-end sweep state update and the fully pipelined back end.
// rst is synchronous, active high; it restores the register defaults and
// clears the sweep state, queue and pipeline valids.
// cmd_stall freezes the back-end pipe; the job queue then fills and
// tick_stall rises once it holds QUEUE_DEPTH jobs.
module pan_tilt_tracker_with_sweep import ptt_pkg::*; #(
  parameter int STEPS       = 200,
  parameter int WEIGHT_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  tick_t             tick,
  output logic              cmd_valid,
  input  logic              cmd_stall,
  output cmd_t              cmd
);

  // front -> queue
  logic      push;
  job_t      push_job;
  // queue -> back
  logic      pop;
  job_t      head;
  q_status_t q_status;

  // Front: classifies each tick as tracking or sweep and sequences waypoints.
  ptt_front #(.STEPS(STEPS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick),
    .q_status   (q_status),
    .push       (push),
    .job        (push_job)
  );

  // Queue: lets the front keep accepting while the output side is stalled.
  ptt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Back: quintic weight interpolation, with the result rounded down toward the lower position.
  ptt_back #(.STEPS(STEPS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd)
  );

endmodule

// ===== rtl/ptt_front.sv =====
// Front end: config registers, tick intake, tracking clamp and sweep sequencing.
module ptt_front import ptt_pkg::*; #(
  parameter int STEPS = 200
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  tick_t             tick,
  input  q_status_t         q_status,
  output logic              push,
  output job_t              job
);

  logic [PIX_W-1:0] center_x, center_y;
  logic [POS_W-1:0] pan_min, pan_max, tilt_min, tilt_max;
  logic [POS_W-1:0] search_tilt, search_pan_mid;

  logic              search_active;
  logic [WP_W-1:0]   waypoint_index;
  logic [STEP_W-1:0] step_count;
  logic [POS_W-1:0]  segment_start_pan, segment_start_tilt;

  logic [POS_W-1:0]  goal_pan, start_pan, start_tilt;
  logic              accept;

  function automatic logic [POS_W-1:0] track_axis(
    input logic [POS_W-1:0] pos,
    input logic [PIX_W-1:0] center,
    input logic [PIX_W-1:0] ball,
    input logic [POS_W-1:0] lo,
    input logic [POS_W-1:0] hi
  );
    logic signed [POS_W+1:0] v;
    v = $signed({2'b00, pos}) + $signed({4'b0000, center}) - $signed({4'b0000, ball});
    if (v < $signed({2'b00, lo})) v = $signed({2'b00, lo});
    if (v > $signed({2'b00, hi})) v = $signed({2'b00, hi});
    return v[POS_W-1:0];
  endfunction

  assign tick_stall = q_status.full;
  assign accept     = tick_valid && !q_status.full;
  assign push       = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= 10'd320;
      center_y       <= 10'd240;
      pan_min        <= 12'd1024;
      pan_max        <= 12'd3072;
      tilt_min       <= 12'd1060;
      tilt_max       <= 12'd2030;
      search_tilt    <= 12'd1800;
      search_pan_mid <= 12'd2048;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTER_X:       center_x       <= cfg_data[PIX_W-1:0];
        REG_CENTER_Y:       center_y       <= cfg_data[PIX_W-1:0];
        REG_PAN_MIN:        pan_min        <= cfg_data;
        REG_PAN_MAX:        pan_max        <= cfg_data;
        REG_TILT_MIN:       tilt_min       <= cfg_data;
        REG_TILT_MAX:       tilt_max       <= cfg_data;
        REG_SEARCH_TILT:    search_tilt    <= cfg_data;
        REG_SEARCH_PAN_MID: search_pan_mid <= cfg_data;
      endcase
    end
  end

  always_comb begin
    case (waypoint_index)
      WP_MAX:  goal_pan = pan_max;
      WP_MIN:  goal_pan = pan_min;
      default: goal_pan = search_pan_mid;
    endcase
  end

  // first tick of a segment uses the live position
  assign start_pan  = (step_count == '0) ? tick.pan_position  : segment_start_pan;
  assign start_tilt = (step_count == '0) ? tick.tilt_position : segment_start_tilt;

  always_comb begin
    if (tick.ball_lost) begin
      job.searching  = 1'b1;
      job.step       = step_count;
      job.start_pan  = start_pan;
      job.start_tilt = start_tilt;
      job.goal_pan   = goal_pan;
      job.goal_tilt  = search_tilt;
    end else begin
      job.searching  = 1'b0;
      job.step       = '0;
      job.start_pan  = track_axis(tick.pan_position, center_x, tick.ball_x, pan_min, pan_max);
      job.start_tilt = track_axis(tick.tilt_position, center_y, tick.ball_y,
                                  tilt_min, tilt_max);
      job.goal_pan   = job.start_pan;
      job.goal_tilt  = job.start_tilt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_active      <= 1'b0;
      waypoint_index     <= WP_MID_OUT;
      step_count         <= '0;
      segment_start_pan  <= '0;
      segment_start_tilt <= '0;
    end else if (accept) begin
      if (!tick.ball_lost) begin
        search_active  <= 1'b0;
        waypoint_index <= WP_MID_OUT;
        step_count     <= '0;
      end else begin
        search_active      <= 1'b1;
        segment_start_pan  <= start_pan;
        segment_start_tilt <= start_tilt;
        if (step_count >= STEP_W'(STEPS)) begin
          step_count     <= '0;
          waypoint_index <= waypoint_index + 2'd1;
        end else begin
          step_count <= step_count + 8'd1;
        end
      end
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step_count <= STEP_W'(STEPS))
    else $error("step_count ran past the segment length");

  a_found_clears: assert property (@(posedge clk) disable iff (rst)
    accept && !tick.ball_lost |=> step_count == '0 && waypoint_index == WP_MID_OUT
      && !search_active)
    else $error("found ball did not restart the sweep");

endmodule

// ===== rtl/ptt_queue.sv =====
// Short job queue between the front end and the interpolation back end.
module ptt_queue import ptt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign q_status.full  = (count == CW'(DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + CW'(1))
    else $error("queue lost a pushed job");

endmodule

// ===== rtl/ptt_back.sv =====
// Back end: weight table, per-axis multiply and command output register.
module ptt_back import ptt_pkg::*; #(
  parameter int STEPS       = 200,
  parameter int WEIGHT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      cmd_valid,
  input  logic      cmd_stall,
  output cmd_t      cmd
);

  localparam int WW = WEIGHT_BITS + 1;        // weight reaches 1.0
  localparam int PRW = WW + POS_W;
  localparam int ROM_N = 1 << STEP_W;
  localparam logic [PRW-1:0] ROUND_UP = {{(POS_W + 1){1'b0}}, {WEIGHT_BITS{1'b1}}};

  // minimum-jerk weight table, floor(w(t) * 2^WEIGHT_BITS), 1.0 from t = STEPS on
  logic [WW-1:0] weight_rom [ROM_N];

  for (genvar t = 0; t < ROM_N; t++) begin : g_rom
    localparam bit [63:0] N   = 64'(STEPS);
    localparam bit [63:0] TT  = (t < STEPS) ? 64'(t) : 64'd0;
    localparam bit [63:0] NUM = TT * TT * TT * (64'd10 * N * N + 64'd6 * TT * TT - 64'd15 * N * TT);
    localparam bit [63:0] DEN = N * N * N * N * N;
    localparam bit [63:0] WV  = (t < STEPS) ? ((NUM << WEIGHT_BITS) / DEN)
                                            : (64'd1 << WEIGHT_BITS);
    assign weight_rom[t] = WV[WW-1:0];
  end

  logic en;
  logic s1_valid, s2_valid;

  logic [WW-1:0]    s1_w;
  logic             s1_search, s1_pan_up, s1_tilt_up;
  logic [POS_W-1:0] s1_pan_mag, s1_tilt_mag, s1_pan_start, s1_tilt_start;

  logic             s2_search, s2_pan_up, s2_tilt_up;
  logic [POS_W-1:0] s2_pan_start, s2_tilt_start;
  logic [PRW-1:0]   s2_pan_prod, s2_tilt_prod;

  logic [PRW-1:0]   pan_sum, tilt_sum;
  logic [POS_W-1:0] pan_q, tilt_q;

  // whole pipe holds while a finished command waits
  assign en  = !cmd_valid || !cmd_stall;
  assign pop = en && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      cmd_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !q_status.empty;
      s2_valid  <= s1_valid;
      cmd_valid <= s2_valid;
    end
  end

  assign pan_sum  = s2_pan_prod  + (s2_pan_up  ? '0 : ROUND_UP);
  assign tilt_sum = s2_tilt_prod + (s2_tilt_up ? '0 : ROUND_UP);
  assign pan_q    = pan_sum[WEIGHT_BITS +: POS_W];
  assign tilt_q   = tilt_sum[WEIGHT_BITS +: POS_W];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w          <= weight_rom[head.step];
      s1_search     <= head.searching;
      s1_pan_up     <= head.goal_pan >= head.start_pan;
      s1_tilt_up    <= head.goal_tilt >= head.start_tilt;
      s1_pan_mag    <= (head.goal_pan >= head.start_pan) ? head.goal_pan - head.start_pan
                                                         : head.start_pan - head.goal_pan;
      s1_tilt_mag   <= (head.goal_tilt >= head.start_tilt) ? head.goal_tilt - head.start_tilt
                                                           : head.start_tilt - head.goal_tilt;
      s1_pan_start  <= head.start_pan;
      s1_tilt_start <= head.start_tilt;

      s2_search     <= s1_search;
      s2_pan_up     <= s1_pan_up;
      s2_tilt_up    <= s1_tilt_up;
      s2_pan_start  <= s1_pan_start;
      s2_tilt_start <= s1_tilt_start;
      s2_pan_prod   <= PRW'(s1_w) * PRW'(s1_pan_mag);
      s2_tilt_prod  <= PRW'(s1_w) * PRW'(s1_tilt_mag);

      cmd.searching    <= s2_search;
      cmd.pan_command  <= s2_pan_up  ? s2_pan_start  + pan_q  : s2_pan_start  - pan_q;
      cmd.tilt_command <= s2_tilt_up ? s2_tilt_start + tilt_q : s2_tilt_start - tilt_q;
    end
  end

  a_track_exact: assert property (@(posedge clk) disable iff (rst)
    en && s2_valid && !s2_search |=> cmd.pan_command == $past(s2_pan_start)
      && cmd.tilt_command == $past(s2_tilt_start))
    else $error("tracking command altered by interpolator");

endmodule
